// ===== design/pcf_pkg.sv =====
// shared types, constants and the crc-32 byte fold for the png chunk framer
// no dependencies
package pcf_pkg;

    localparam int unsigned LEN_W       = 31;
    localparam int unsigned TYPE_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CRC_W       = 32;
    localparam int unsigned HDR_BYTES   = 8;
    localparam int unsigned CRC_BYTES   = 4;
    localparam int unsigned HDR_CNT_W   = 4;
    localparam int unsigned CRC_CNT_W   = 3;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                opcode;
        logic [LEN_W-1:0]       chunk_length;
        logic [TYPE_W-1:0]      chunk_type;
        logic [BYTE_W-1:0]      data_byte;
    } t_item;

    // reflected crc-32, one byte per call
    function automatic logic [CRC_W-1:0] crc_fold(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = CRC_POLY ^ (c >> 1);
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/pcf_in_reg.sv =====
// input register stage of the png chunk framer
// depends on pcf_pkg for the item struct
module pcf_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_opcode,
    input  logic [30:0]     i_chunk_length,
    input  logic [31:0]     i_chunk_type,
    input  logic [7:0]      i_data_byte,
    input  logic            i_take,
    output logic            o_item_valid,
    output pcf_pkg::t_item  o_item
);
    import pcf_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // slot frees in the same cycle the core takes the held item
    assign o_in_stall = r_valid && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.opcode       <= t_opcode'(i_opcode);
            r_item.chunk_length <= i_chunk_length;
            r_item.chunk_type   <= i_chunk_type;
            r_item.data_byte    <= i_data_byte;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== design/pcf_core.sv =====
// chunk sequencer: header, data and crc byte emission, running crc, output register
// depends on pcf_pkg for constants, the item struct and crc_fold
module pcf_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  pcf_pkg::t_item  i_item,
    output logic            o_take,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_chunk_end
);
    import pcf_pkg::*;

    logic [HDR_CNT_W-1:0]        r_hdr_cnt, n_hdr_cnt;
    logic [HDR_BYTES*BYTE_W-1:0] r_hdr, n_hdr;
    logic                        r_len_zero, n_len_zero;
    logic [CRC_CNT_W-1:0]        r_crc_cnt, n_crc_cnt;
    logic [CRC_W-1:0]            r_crc, n_crc;
    logic [LEN_W-1:0]            r_remaining, n_remaining;
    logic                        r_open, n_open;
    logic                        r_out_valid;
    logic [BYTE_W-1:0]           r_out_byte, n_out_byte;
    logic                        r_out_end, n_out_end;

    logic              w_advance;
    logic              w_busy;
    logic              w_emit;
    logic [CRC_W-1:0]  w_crc_inv;

    assign w_advance = !r_out_valid || !i_out_stall;
    assign w_busy    = (r_hdr_cnt != '0) || (r_crc_cnt != '0);
    assign w_crc_inv = r_crc ^ CRC_ONES;

    // a start only loads the header; a data byte needs the output slot while a chunk is open
    always_comb begin
        o_take = 1'b0;
        if (i_item_valid && !w_busy) begin
            if (i_item.opcode == OP_START || !r_open) begin
                o_take = 1'b1;
            end else begin
                o_take = w_advance;
            end
        end
    end

    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr       = r_hdr;
        n_len_zero  = r_len_zero;
        n_crc_cnt   = r_crc_cnt;
        n_crc       = r_crc;
        n_remaining = r_remaining;
        n_open      = r_open;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;
        w_emit      = 1'b0;

        if (r_hdr_cnt != '0) begin
            if (w_advance) begin
                w_emit     = 1'b1;
                n_out_byte = r_hdr[HDR_BYTES*BYTE_W-1 -: BYTE_W];
                n_out_end  = 1'b0;
                n_hdr      = r_hdr << BYTE_W;
                n_hdr_cnt  = r_hdr_cnt - 1'b1;
                // last four header bytes are the type, covered by the crc
                if (r_hdr_cnt <= HDR_CNT_W'(CRC_BYTES)) begin
                    n_crc = crc_fold(r_crc, r_hdr[HDR_BYTES*BYTE_W-1 -: BYTE_W]);
                end
                if (r_hdr_cnt == HDR_CNT_W'(1) && r_len_zero) begin
                    n_crc_cnt = CRC_CNT_W'(CRC_BYTES);
                end
            end
        end else if (r_crc_cnt != '0) begin
            if (w_advance) begin
                w_emit    = 1'b1;
                n_crc_cnt = r_crc_cnt - 1'b1;
                n_out_end = (r_crc_cnt == CRC_CNT_W'(1));
                case (r_crc_cnt)
                    CRC_CNT_W'(4): n_out_byte = w_crc_inv[31:24];
                    CRC_CNT_W'(3): n_out_byte = w_crc_inv[23:16];
                    CRC_CNT_W'(2): n_out_byte = w_crc_inv[15:8];
                    default:       n_out_byte = w_crc_inv[7:0];
                endcase
                if (r_crc_cnt == CRC_CNT_W'(1)) begin
                    n_crc = CRC_ONES;
                end
            end
        end else if (o_take) begin
            if (i_item.opcode == OP_START) begin
                n_hdr       = {1'b0, i_item.chunk_length, i_item.chunk_type};
                n_hdr_cnt   = HDR_CNT_W'(HDR_BYTES);
                n_len_zero  = (i_item.chunk_length == '0);
                n_crc       = CRC_ONES;
                n_remaining = i_item.chunk_length;
                n_open      = (i_item.chunk_length != '0);
            end else if (r_open) begin
                w_emit      = 1'b1;
                n_out_byte  = i_item.data_byte;
                n_out_end   = 1'b0;
                n_crc       = crc_fold(r_crc, i_item.data_byte);
                n_remaining = r_remaining - 1'b1;
                if (r_remaining == LEN_W'(1)) begin
                    n_open    = 1'b0;
                    n_crc_cnt = CRC_CNT_W'(CRC_BYTES);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt   <= '0;
            r_crc_cnt   <= '0;
            r_crc       <= CRC_ONES;
            r_remaining <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hdr_cnt   <= n_hdr_cnt;
            r_crc_cnt   <= n_crc_cnt;
            r_crc       <= n_crc;
            r_remaining <= n_remaining;
            r_open      <= n_open;
            r_out_valid <= w_emit || !w_advance;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr      <= n_hdr;
        r_len_zero <= n_len_zero;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_chunk_end = r_out_end;

    a_hdr_crc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_hdr_cnt != '0) && (r_crc_cnt != '0)))
        else $error("header and crc emission overlap");

    a_hdr_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= HDR_CNT_W'(HDR_BYTES))
        else $error("header count out of range");

    a_open_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_remaining != '0))
        else $error("open chunk with no bytes remaining");

    a_crc_reseed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_crc_cnt == CRC_CNT_W'(1) && w_advance) |=>
            (r_crc == CRC_ONES && r_crc_cnt == '0 && r_out_valid && r_out_end))
        else $error("crc not reseeded after last crc byte");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> !w_busy)
        else $error("item taken during emission");

endmodule

// ===== design/png_chunk_framer_crc32_top.sv =====
// png chunk framer with crc-32: top level, input register plus sequencer core
// depends on pcf_pkg, pcf_in_reg and pcf_core
// path: a data byte is held in the input register, then in the output register
// throughput: one data byte per cycle while i_out_stall is low, set by the single
//   byte-wide output register; a start item holds the input for the header load, the
//   8 header bytes and, at zero length, 4 crc bytes; a chunk's last byte for the 4 crc bytes
// reset: synchronous active-low i_rst_n empties both registers, closes any chunk and
//   seeds the crc to all ones
module png_chunk_framer_crc32_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [30:0] i_chunk_length,
    input  logic [31:0] i_chunk_type,
    input  logic [7:0]  i_data_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_chunk_end
);
    import pcf_pkg::*;

    // held item and its handoff into the core
    logic  w_item_valid;
    t_item w_item;
    logic  w_take;

    // input register: one item waits here while the core finishes the last one
    pcf_in_reg u_in_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_chunk_length (i_chunk_length),
        .i_chunk_type   (i_chunk_type),
        .i_data_byte    (i_data_byte),
        .i_take         (w_take),
        .o_item_valid   (w_item_valid),
        .o_item         (w_item)
    );

    // core: header shift, crc fold per byte, crc emission, output register
    // a data byte with no chunk open is taken and dropped with no transfer out
    pcf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_chunk_end  (o_chunk_end)
    );

endmodule
